// File: rtl/core/plics_pkg.sv
// Shared types and constants of the piecewise-linear inverse-CDF sampler.
// Used by every module below rtl/core; depends on nothing.
`default_nettype none
package plics_pkg;

  localparam int unsigned MAX_POINTS_DEF = 256;

  localparam int unsigned IDX_W   = 8;
  localparam int unsigned E_W     = 16;
  localparam int unsigned W_W     = 16;
  localparam int unsigned U_W     = 32;
  localparam int unsigned CNT_W   = 9;
  localparam int unsigned S_W     = 32;
  localparam int unsigned C_W     = 41;
  localparam int unsigned D_W     = 33;
  localparam int unsigned SLOPE_FRAC = 14;
  localparam int unsigned DEN_SHIFT  = 7;

  localparam int unsigned RR_W    = 64;
  localparam int unsigned ROOT_W  = 32;
  localparam int unsigned DIV_NW  = 40;
  localparam int unsigned DIV_DW  = 33;

  localparam int unsigned IN_TDATA_W  = 72;
  localparam int unsigned OUT_TDATA_W = 16;

  // read address source for all knot tables
  typedef enum logic [1:0] {
    RD_PREV = 2'd0,
    RD_LAST = 2'd1,
    RD_J    = 2'd2
  } rd_sel_t;

  typedef struct packed {
    logic    capture;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    load_calc;
    logic    load_wr;
    logic    chk;
    logic    nr_set;
    logic    mul_lo;
    logic    mul_t;
    logic    j_dec;
    logic    d_load;
    logic    fetch_cap;
    logic    p_sum;
    logic    rr_calc;
    logic    sqrt_start;
    logic    den_calc;
    logic    div_start;
    logic    div_slope;
    logic    res_calc;
    logic    out_load;
  } plics_cmd_t;

  typedef struct packed {
    logic idx_ok;
    logic idx_zero;
    logic no_data;
    logic scan_hit;
    logic div_busy;
    logic sqrt_busy;
    logic out_full;
  } plics_sts_t;

endpackage
`default_nettype wire

// File: rtl/core/piecewise_linear_inverse_cdf_sampler.sv
// Top level of the piecewise-linear inverse-CDF sampler.
// Depends on plics_pkg, plics_ctrl and plics_dp.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------------
//  cfg     | in        | cfg_we             | cfg_data: point_count
//  s       | in        | s_tvalid/s_tready  | s_tdata: knot or fraction, s_tuser: req_type
//  m       | out       | m_tvalid/m_tready  | m_tdata: sampled_energy, m_tuser: not_ready
//
// Sequencing: a knot load above index 0 waits on the 40-step shared divider
// that forms the segment slope. A sample with data scans the cumulative table
// downward (one table read and one compare per knot it visits), then runs the
// square root and then the divide.
// One item is in work at a time; s_tready is high only while the controller idles.
// Reset (rst, synchronous) clears point_count, the controller and the result
// valid flag; the knot tables are not cleared and hold nothing until loaded.
// A stalled m side holds the finished transfer in the result register while
// the next item is already accepted and worked on.
`default_nettype none
module piecewise_linear_inverse_cdf_sampler #(
  parameter int unsigned MAX_POINTS = plics_pkg::MAX_POINTS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [plics_pkg::CNT_W-1:0]        cfg_data,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // point_index[7:0], point_energy[23:8], point_weight[39:24], random_fraction[71:40]
  input  wire logic [plics_pkg::IN_TDATA_W-1:0]   s_tdata,
  // req_type[0]
  input  wire logic [0:0]                        s_tuser,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // sampled_energy[15:0]
  output logic      [plics_pkg::OUT_TDATA_W-1:0]  m_tdata,
  // not_ready[0]
  output logic      [0:0]                        m_tuser
);
  import plics_pkg::*;

  plics_cmd_t cmd;
  plics_sts_t sts;

  // controller: walks each transfer through its load or sample sequence
  plics_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_is_sample (s_tuser[0]),
    .s_tready    (s_tready),
    .sts         (sts),
    .cmd         (cmd)
  );

  // datapath: tables, arithmetic units and the output register
  plics_dp #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .in_data    (s_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_ready  (m_tready),
    .out_valid  (m_tvalid),
    .out_energy (m_tdata),
    .out_nr     (m_tuser[0])
  );

endmodule
`default_nettype wire

// File: rtl/core/plics_div.sv
// Restoring divider, one quotient bit per cycle (40-bit by 33-bit).
// Depends on plics_pkg.
`default_nettype none
module plics_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [plics_pkg::DIV_NW-1:0] num,
  input  wire logic [plics_pkg::DIV_DW-1:0] den,
  output logic      [plics_pkg::DIV_NW-1:0] quo,
  output logic                             busy
);
  import plics_pkg::*;

  localparam int unsigned CW = $clog2(DIV_NW + 1);

  logic [DIV_DW-1:0] rem;
  logic [DIV_DW-1:0] dreg;
  logic [CW-1:0]     cnt;
  logic [DIV_DW:0]   trial;
  logic              take;

  assign trial = {rem, quo[DIV_NW-1]};
  assign take  = trial >= {1'b0, dreg};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(DIV_NW);
      rem  <= '0;
      quo  <= num;
      dreg <= den;
    end else if (busy) begin
      // shift in one dividend bit, subtract when it fits
      rem  <= take ? DIV_DW'(trial - {1'b0, dreg}) : trial[DIV_DW-1:0];
      quo  <= {quo[DIV_NW-2:0], take};
      cnt  <= cnt - 1'b1;
      busy <= (cnt != CW'(1));
    end
  end
endmodule
`default_nettype wire

// File: rtl/core/plics_sqrt.sv
// Digit-by-digit integer square root, one result bit per cycle (64-bit in).
// Depends on plics_pkg.
`default_nettype none
module plics_sqrt (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [plics_pkg::RR_W-1:0]   rad_in,
  output logic      [plics_pkg::ROOT_W-1:0] root,
  output logic                            busy
);
  import plics_pkg::*;

  localparam int unsigned CW  = $clog2(ROOT_W + 1);
  localparam int unsigned REM_W = ROOT_W + 1;

  logic [RR_W-1:0]  rad;
  logic [REM_W-1:0] rem;
  logic [CW-1:0]    cnt;
  logic [REM_W+1:0] rem2;
  logic [REM_W+1:0] trial;
  logic             take;

  assign rem2  = {rem, rad[RR_W-1 -: 2]};
  assign trial = {1'b0, root, 2'b01};
  assign take  = rem2 >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(ROOT_W);
      rad  <= rad_in;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rem  <= take ? REM_W'(rem2 - trial) : rem2[REM_W-1:0];
      root <= {root[ROOT_W-2:0], take};
      rad  <= {rad[RR_W-3:0], 2'b00};
      cnt  <= cnt - 1'b1;
      busy <= (cnt != CW'(1));
    end
  end
endmodule
`default_nettype wire

// File: rtl/core/plics_dp.sv
// Datapath: knot tables, load arithmetic, sample arithmetic, result register.
// Depends on plics_pkg, plics_div and plics_sqrt.
`default_nettype none
module plics_dp #(
  parameter int unsigned MAX_POINTS = plics_pkg::MAX_POINTS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [plics_pkg::CNT_W-1:0]       cfg_data,
  input  wire logic [plics_pkg::IN_TDATA_W-1:0]  in_data,
  input  wire plics_pkg::plics_cmd_t            cmd,
  output plics_pkg::plics_sts_t                 sts,
  input  wire logic                             out_ready,
  output logic                                  out_valid,
  output logic      [plics_pkg::E_W-1:0]        out_energy,
  output logic                                  out_nr
);
  import plics_pkg::*;

  localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned NW = $clog2(MAX_POINTS + 1);

  // knot tables
  logic [E_W-1:0] energy_mem [MAX_POINTS];
  logic [W_W-1:0] weight_mem [MAX_POINTS];
  logic [S_W-1:0] slope_mem  [MAX_POINTS];
  logic [C_W-1:0] cum_mem    [MAX_POINTS];
  logic [E_W-1:0] e_q;
  logic [W_W-1:0] w_q;
  logic [S_W-1:0] s_q;
  logic [C_W-1:0] c_q;

  logic [CNT_W-1:0] pc;
  logic [NW-1:0]    n_pts;
  logic [IDX_W-1:0] idx;
  logic [E_W-1:0]   ein;
  logic [W_W-1:0]   win;
  logic [U_W-1:0]   u;
  logic [AW-1:0]    j;
  logic [AW-1:0]    rd_addr;
  logic [AW-1:0]    wr_addr;

  // load path
  logic [E_W-1:0]   de;
  logic [W_W-1:0]   mag;
  logic             neg_c;
  logic             neg;
  logic             de_zero;
  logic [D_W-1:0]   prod;
  logic [S_W-1:0]   slope_new;

  // sample path
  logic [C_W-1:0]   total;
  logic [E_W-1:0]   elast;
  logic [U_W-1:0]   lo_hi;
  logic [C_W-1:0]   t;
  logic [D_W-1:0]   d;
  logic [C_W-1:0]   diff;
  logic [W_W-1:0]   w;
  logic [E_W-1:0]   ej;
  logic             sneg;
  logic [S_W-1:0]   smag;
  logic [RR_W-1:0]  w2;
  logic [RR_W-1:0]  pm;
  logic [RR_W-1:0]  p;
  logic [RR_W-1:0]  rr;
  logic [DIV_DW-1:0] den;
  logic [E_W:0]     sum;

  logic [DIV_NW-1:0] div_num;
  logic [DIV_DW-1:0] div_den;
  logic [DIV_NW-1:0] quo;
  logic [ROOT_W-1:0] root;

  always_comb begin
    if (32'(pc) > MAX_POINTS) begin
      n_pts = NW'(MAX_POINTS);
    end else begin
      n_pts = NW'(pc);
    end
  end

  always_comb begin
    unique case (cmd.rd_sel)
      RD_PREV: rd_addr = AW'(idx) - 1'b1;
      RD_LAST: rd_addr = AW'(n_pts - 1'b1);
      RD_J:    rd_addr = j;
      default: rd_addr = j;
    endcase
  end

  assign wr_addr = AW'(idx);

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      e_q <= energy_mem[rd_addr];
      w_q <= weight_mem[rd_addr];
      s_q <= slope_mem[rd_addr];
      c_q <= cum_mem[rd_addr];
    end
    if (cmd.load_wr) begin
      energy_mem[wr_addr] <= ein;
      weight_mem[wr_addr] <= win;
      cum_mem[wr_addr]    <= sts.idx_zero ? '0 : C_W'(c_q + {8'd0, prod});
    end
    if (cmd.load_wr && !sts.idx_zero) begin
      slope_mem[wr_addr - 1'b1] <= slope_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= '0;
    end else if (cfg_we) begin
      pc <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      idx <= in_data[7:0];
      ein <= in_data[23:8];
      win <= in_data[39:24];
      u   <= in_data[71:40];
    end
  end

  // load arithmetic
  assign de    = (ein > e_q) ? E_W'(ein - e_q) : '0;
  assign neg_c = win < w_q;
  assign mag   = neg_c ? W_W'(w_q - win) : W_W'(win - w_q);
  assign slope_new = de_zero ? '0 :
                     (neg ? S_W'(0) - quo[S_W-1:0] : quo[S_W-1:0]);

  always_ff @(posedge clk) begin
    if (cmd.load_calc) begin
      prod    <= D_W'(({1'b0, w_q} + {1'b0, win}) * de);
      neg     <= neg_c;
      de_zero <= (de == '0);
    end
  end

  // sample arithmetic
  assign diff = (t >= c_q) ? C_W'(t - c_q) : '0;

  always_ff @(posedge clk) begin
    if (cmd.chk) begin
      total <= c_q;
      elast <= e_q;
    end
    if (cmd.mul_lo) begin
      lo_hi <= U_W'((64'(u) * 64'(total[31:0])) >> 32);
    end
    if (cmd.mul_t) begin
      t <= C_W'(u * total[C_W-1:32]) + C_W'(lo_hi);
    end
    if (cmd.mul_t) begin
      j <= AW'(n_pts - NW'(2));
    end else if (cmd.j_dec) begin
      j <= j - 1'b1;
    end
    if (cmd.d_load) begin
      d <= (diff[C_W-1:D_W] != '0) ? '1 : diff[D_W-1:0];
    end
    if (cmd.fetch_cap) begin
      w    <= w_q;
      ej   <= e_q;
      sneg <= s_q[S_W-1];
      smag <= s_q[S_W-1] ? S_W'(0) - s_q : s_q;
      w2   <= RR_W'({32'(w_q) * 32'(w_q), 14'd0});
    end
    if (cmd.p_sum) begin
      pm <= 64'(smag) * 64'(d[31:0]);
    end
    if (cmd.rr_calc) begin
      p <= pm + (d[D_W-1] ? {smag, 32'd0} : '0);
    end
    if (cmd.den_calc) begin
      den <= DIV_DW'({w, 7'd0}) + DIV_DW'(root);
    end
  end

  // radicand follows p directly; sqrt_start takes it the cycle after p settles
  always_comb begin
    rr = sneg ? ((w2 > p) ? w2 - p : '0) : w2 + p;
  end

  assign div_num = cmd.div_slope ? DIV_NW'({mag, 14'd0}) : DIV_NW'({d, 7'd0});
  assign div_den = cmd.div_slope ? DIV_DW'(de) : den;

  plics_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .quo   (quo),
    .busy  (sts.div_busy)
  );

  plics_sqrt u_sqrt (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.sqrt_start),
    .rad_in (rr),
    .root   (root),
    .busy   (sts.sqrt_busy)
  );

  // final energy: clamp at the last knot
  assign sum = {1'b0, ej} + {1'b0, quo[E_W-1:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  logic [E_W-1:0] res_e;
  logic           res_nr;

  always_ff @(posedge clk) begin
    if (cmd.nr_set) begin
      res_e  <= '0;
      res_nr <= 1'b1;
    end else if (cmd.res_calc) begin
      res_nr <= 1'b0;
      if (den == '0) begin
        res_e <= (ej > elast) ? elast : ej;
      end else if (quo[DIV_NW-1:E_W] != '0 || sum > {1'b0, elast}) begin
        res_e <= elast;
      end else begin
        res_e <= sum[E_W-1:0];
      end
    end
    if (cmd.out_load) begin
      out_energy <= res_e;
      out_nr     <= res_nr;
    end
  end

  assign sts.idx_ok   = 32'(idx) < MAX_POINTS;
  assign sts.idx_zero = (idx == '0);
  assign sts.no_data  = (n_pts < NW'(2)) || (c_q == '0);
  assign sts.scan_hit = (j == '0) || (c_q <= t);
  assign sts.out_full = out_valid && !out_ready;

endmodule
`default_nettype wire

// File: rtl/core/plics_ctrl.sv
// Controller state machine: sequences loads and samples through the datapath.
// Depends on plics_pkg.
`default_nettype none
module plics_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  input  wire logic                  s_is_sample,
  output logic                       s_tready,
  input  wire plics_pkg::plics_sts_t sts,
  output plics_pkg::plics_cmd_t      cmd
);
  import plics_pkg::*;

  typedef enum logic [19:0] {
    ST_IDLE   = 20'h00001,
    ST_L_RD   = 20'h00002,
    ST_L_CALC = 20'h00004,
    ST_L_DIV  = 20'h00008,
    ST_L_WR   = 20'h00010,
    ST_S_RD   = 20'h00020,
    ST_S_CHK  = 20'h00040,
    ST_S_M1   = 20'h00080,
    ST_S_M2   = 20'h00100,
    ST_S_SRD  = 20'h00200,
    ST_S_SCMP = 20'h00400,
    ST_S_FET  = 20'h00800,
    ST_S_MUL  = 20'h01000,
    ST_S_P    = 20'h02000,
    ST_S_RR   = 20'h04000,
    ST_S_SQS  = 20'h08000,
    ST_S_SQW  = 20'h10000,
    ST_S_DEN  = 20'h20000,
    ST_S_DVW  = 20'h40000,
    ST_S_OUT  = 20'h80000
  } state_t;

  state_t state;
  state_t state_next;
  logic   res_pending;

  assign s_tready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // ST_S_DVW entered first time: launch divider; res computed as it finishes
  always_ff @(posedge clk) begin
    if (rst) begin
      res_pending <= 1'b0;
    end else begin
      res_pending <= (state == ST_S_DEN);
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.rd_sel = RD_J;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = s_is_sample ? ST_S_RD : ST_L_RD;
        end
      end
      ST_L_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_PREV;
        if (!sts.idx_ok) begin
          state_next = ST_IDLE;
        end else if (sts.idx_zero) begin
          state_next = ST_L_WR;
        end else begin
          state_next = ST_L_CALC;
        end
      end
      ST_L_CALC: begin
        cmd.load_calc = 1'b1;
        cmd.div_start = 1'b1;
        cmd.div_slope = 1'b1;
        state_next    = ST_L_DIV;
      end
      ST_L_DIV: begin
        if (!sts.div_busy) begin
          state_next = ST_L_WR;
        end
      end
      ST_L_WR: begin
        cmd.load_wr = 1'b1;
        state_next  = ST_IDLE;
      end
      ST_S_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_LAST;
        state_next = ST_S_CHK;
      end
      ST_S_CHK: begin
        cmd.chk = 1'b1;
        if (sts.no_data) begin
          cmd.nr_set = 1'b1;
          state_next = ST_S_OUT;
        end else begin
          state_next = ST_S_M1;
        end
      end
      ST_S_M1: begin
        cmd.mul_lo = 1'b1;
        state_next = ST_S_M2;
      end
      ST_S_M2: begin
        cmd.mul_t  = 1'b1;
        state_next = ST_S_SRD;
      end
      ST_S_SRD: begin
        cmd.rd_en  = 1'b1;
        state_next = ST_S_SCMP;
      end
      ST_S_SCMP: begin
        if (sts.scan_hit) begin
          cmd.d_load = 1'b1;
          state_next = ST_S_FET;
        end else begin
          cmd.j_dec  = 1'b1;
          state_next = ST_S_SRD;
        end
      end
      ST_S_FET: begin
        cmd.rd_en  = 1'b1;
        state_next = ST_S_MUL;
      end
      ST_S_MUL: begin
        cmd.fetch_cap = 1'b1;
        state_next    = ST_S_P;
      end
      ST_S_P: begin
        cmd.p_sum  = 1'b1;
        state_next = ST_S_RR;
      end
      ST_S_RR: begin
        cmd.rr_calc = 1'b1;
        state_next  = ST_S_SQS;
      end
      ST_S_SQS: begin
        cmd.sqrt_start = 1'b1;
        state_next     = ST_S_SQW;
      end
      ST_S_SQW: begin
        if (!sts.sqrt_busy) begin
          state_next = ST_S_DEN;
        end
      end
      ST_S_DEN: begin
        cmd.den_calc = 1'b1;
        state_next   = ST_S_DVW;
      end
      ST_S_DVW: begin
        if (res_pending) begin
          cmd.div_start = 1'b1;
        end else if (!sts.div_busy) begin
          cmd.res_calc = 1'b1;
          state_next   = ST_S_OUT;
        end
      end
      ST_S_OUT: begin
        if (!sts.out_full) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end
endmodule
`default_nettype wire

// File: dv/piecewise_linear_inverse_cdf_sampler_tb.sv
// Self-checking testbench for the piecewise-linear inverse-CDF sampler.
// Predicts sampled energies from the loaded knots and checks each result transfer.
// Depends on plics_pkg and piecewise_linear_inverse_cdf_sampler.
`default_nettype none

typedef struct {
  bit        is_sample;
  bit [7:0]  idx;
  bit [15:0] energy;
  bit [15:0] weight;
  bit [31:0] frac;
} knot_req_t;

typedef struct {
  bit [15:0] energy;
  bit        not_ready;
} draw_result_t;

// Spectrum predictor plus the queue of energies still owed by the block
class energy_scoreboard;
  localparam int unsigned NPTS = plics_pkg::MAX_POINTS_DEF;
  localparam longint unsigned D_CAP = (64'd1 << plics_pkg::D_W) - 1;

  bit [15:0] energy_tbl[NPTS];
  bit [15:0] weight_tbl[NPTS];
  int        slope_tbl[NPTS];
  bit [40:0] area_tbl[NPTS];
  int unsigned point_count;
  draw_result_t owed_q[$];
  int errors;

  static function longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, c;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (c * c <= v) r = c;
    end
    return r;
  endfunction

  function void load_knot(int k, bit [15:0] e, bit [15:0] w);
    longint unsigned pe, pw, de;
    bit [31:0] mag, q;
    int s;
    energy_tbl[k] = e;
    weight_tbl[k] = w;
    if (k == 0) begin
      area_tbl[0] = '0;
      return;
    end
    pe = energy_tbl[k-1];
    pw = weight_tbl[k-1];
    de = (e > pe) ? e - pe : 0;
    s = 0;
    if (de != 0) begin
      mag = (w < pw) ? pw - w : w - pw;
      q = (mag << plics_pkg::SLOPE_FRAC) / de;
      s = (w < pw) ? -int'(q) : int'(q);
    end
    slope_tbl[k-1] = s;
    // doubled trapezoid area, wraps at 41 bits on assignment
    area_tbl[k] = area_tbl[k-1] + (pw + w) * de;
  endfunction

  function draw_result_t draw(bit [31:0] frac);
    draw_result_t r;
    int unsigned n, j;
    longint unsigned total, u, t, d, w, w2, p, rr, den, x, res, elast;
    int s;
    n = (point_count > NPTS) ? NPTS : point_count;
    if (n < 2 || area_tbl[n-1] == 0) begin
      r.energy = '0;
      r.not_ready = 1'b1;
      return r;
    end
    total = area_tbl[n-1];
    u = frac;
    t = u * (total >> 32) + ((u * (total & 64'hFFFF_FFFF)) >> 32);
    j = n - 2;
    while (j > 0 && area_tbl[j] > t) j--;
    d = (t >= area_tbl[j]) ? t - area_tbl[j] : 0;
    if (d > D_CAP) d = D_CAP;
    w = weight_tbl[j];
    s = slope_tbl[j];
    w2 = (w * w) << plics_pkg::SLOPE_FRAC;
    if (s >= 0) begin
      rr = w2 + longint'(s) * d;
    end else begin
      p = longint'(-s) * d;
      rr = (w2 > p) ? w2 - p : 0;
    end
    den = (w << plics_pkg::DEN_SHIFT) + int_sqrt(rr);
    x = (den != 0) ? (d << plics_pkg::DEN_SHIFT) / den : 0;
    elast = energy_tbl[n-1];
    res = energy_tbl[j] + x;
    if (x > 64'hFFFF || res > elast) res = elast;
    r.energy = res[15:0];
    r.not_ready = 1'b0;
    return r;
  endfunction

  function void note_input(knot_req_t it);
    if (it.is_sample) owed_q.push_back(draw(it.frac));
    else load_knot(it.idx, it.energy, it.weight);
  endfunction

  function void check_result(bit [15:0] energy, bit nr);
    draw_result_t e;
    if (owed_q.size() == 0) begin
      $display("%0t: unexpected result transfer energy=%0d not_ready=%0b",
               $time, energy, nr);
      errors++;
      return;
    end
    e = owed_q.pop_front();
    if (e.energy !== energy) begin
      $display("%0t: sampled_energy expected %0d actual %0d", $time, e.energy, energy);
      errors++;
    end
    if (e.not_ready !== nr) begin
      $display("%0t: not_ready expected %0b actual %0b", $time, e.not_ready, nr);
      errors++;
    end
  endfunction
endclass

module piecewise_linear_inverse_cdf_sampler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TOTAL_ITEMS = 1900;
  localparam int SETTLE      = 800;  // worst-case sample time with a full table
  localparam int HOLD_CYCLES = 400;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [8:0]  cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [71:0] s_tdata = '0;
  logic [0:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic [0:0]  m_tuser;

  energy_scoreboard sb = new();

  int sent = 0;
  int idle_mode = 0;   // 0: sender light, receiver heavy; 1: swapped; 2: none
  int hold_req = 0;    // bumped by the stimulus to ask for one long stall
  int filled = 0;      // knots 0..filled-1 hold defined table entries

  always #5 clk = ~clk;

  piecewise_linear_inverse_cdf_sampler i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  // Receiver: check each result transfer, then pick tready for the next cycle
  initial begin
    int hold_seen, hold_left, pct;
    hold_seen = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser[0]);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      pct = (idle_mode == 0) ? 51 : (idle_mode == 1) ? 18 : 0;
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= pct);
      end
    end
  end

  // Offer one item, hold it until the transfer, note it for prediction
  task automatic put(bit smp, bit [7:0] idx, bit [15:0] e, bit [15:0] w, bit [31:0] u);
    knot_req_t it;
    int gap, pct;
    pct = (idle_mode == 0) ? 18 : (idle_mode == 1) ? 51 : 0;
    gap = 0;
    while ($urandom_range(99) < pct && gap < 40) gap++;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= smp;
    s_tdata  <= {u, w, e, idx};
    do @(posedge clk); while (!s_tready);
    it = '{smp, idx, e, w, u};
    sb.note_input(it);
    if (!smp && idx == filled) filled++;
    sent++;
  endtask

  task automatic sample(bit [31:0] u);
    put(1'b1, 8'($urandom()), 16'($urandom()), 16'($urandom()), u);
  endtask

  task automatic load(int k, bit [15:0] e, bit [15:0] w);
    put(1'b0, 8'(k), e, w, $urandom());
  endtask

  // Drain, let the last load finish, then write point_count
  task automatic set_count(int unsigned v);
    s_tvalid <= 1'b0;
    while (sb.owed_q.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= 9'(v);
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.point_count = v;
  endtask

  function automatic bit [31:0] pick_frac();
    int r;
    r = $urandom_range(99);
    if (r < 5) return '0;
    if (r < 10) return '1;
    return $urandom();
  endfunction

  function automatic bit [15:0] pick_weight();
    int r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 15) return 16'hFFFF;
    return 16'($urandom());
  endfunction

  initial begin
    int unsigned n, tgt, quota, span, prev, phase, r, k;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty table, single knot, both fraction extremes, zero weight
    // at zero offset, non-increasing energy, flat segment, falling segment
    set_count(0);
    sample($urandom());
    load(0, 16'd0, 16'd0);
    set_count(1);
    sample($urandom());
    set_count(2);
    load(1, 16'hFFFF, 16'hFFFF);
    sample('0);
    sample('1);
    sample($urandom());
    load(1, 16'd0, 16'hFFFF);
    sample($urandom());
    load(0, 16'd100, 16'd500);
    load(1, 16'd1100, 16'd500);
    sample($urandom());
    sample('1);
    set_count(3);
    load(2, 16'd2100, 16'd0);
    sample('1);
    sample($urandom());

    // Random phases: fill the table up to the count, then mostly draw
    phase = 0;
    while (sent < TOTAL_ITEMS) begin
      idle_mode = (sent < TOTAL_ITEMS / 3) ? 0 : (sent < 2 * TOTAL_ITEMS / 3) ? 1 : 2;
      r = $urandom_range(99);
      if (r < 10) n = $urandom_range(0, 1);
      else if (r < 20) n = $urandom_range(256, 511);
      else if (r < 45) n = $urandom_range(2, 40);
      else n = $urandom_range(2, 8);
      set_count(n);
      tgt = (n > 256) ? 256 : n;
      quota = (tgt >= 64) ? 30 : 80;
      if (phase == 2) hold_req++;
      while (quota > 0) begin
        if (filled < tgt) begin
          if (filled == 0) begin
            load(0, 16'($urandom_range(0, 200)), pick_weight());
          end else begin
            prev = sb.energy_tbl[filled-1];
            span = (65535 - prev) / (tgt - filled);
            if ($urandom_range(99) < 5) load(filled, 16'($urandom()), pick_weight());
            else load(filled, 16'(prev + $urandom_range(0, span)), pick_weight());
          end
        end else begin
          r = $urandom_range(99);
          if (r < 80) begin
            sample(pick_frac());
          end else begin
            // rewrite a defined knot or the one just past them, content often out of order
            k = $urandom_range(0, (filled > 255) ? 255 : filled);
            load(k, 16'($urandom()), pick_weight());
          end
          quota--;
        end
      end
      phase++;
    end

    s_tvalid <= 1'b0;
    while (sb.owed_q.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (sb.errors == 0 && sb.owed_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #60ms;
    $display("Mismatches found");
    $finish;
  end
endmodule
`default_nettype wire
